// File: sv/ste_pkg.sv
// Shared types and constants of the sinusoidal timestep embedding block.
package ste_pkg;

  // Maximum number of frequencies per timestep
  localparam int unsigned MaxHalf = 64;
  localparam int unsigned IdxW    = $clog2(MaxHalf);
  localparam int unsigned CountW  = 7;
  localparam int unsigned TsW     = 24;
  localparam int unsigned FreqW   = 32;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned ValW    = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 32;

  // Register stages of the quarter-wave sine unit
  localparam int unsigned SineLat = 4;

  // Reset values of the configuration registers
  localparam logic [CountW-1:0] HalfCountRst = 7'd64;
  localparam logic [FreqW-1:0]  FreqRatioRst = 32'd3719269870;

  // 1/(2*pi) in Q0.32 turns
  localparam logic [FreqW-1:0] StartFreq = 32'd683565276;
  localparam logic [63:0]      FreqRound = 64'h0000_0000_8000_0000;

  // Quarter-wave polynomial constants, Q16
  localparam logic [16:0] SinA = 17'd102944;
  localparam logic [15:0] SinB = 16'd42048;
  localparam logic [12:0] SinC = 13'd4640;

  // Full scale of the Q1.14 result
  localparam logic [15:0] SinOne   = 16'd16384;
  localparam logic [15:0] QuarterZ = 16'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHalfCount = 4'd0,
    CfgFreqRatio = 4'd1
  } ste_cfg_idx_e;

  typedef enum logic [1:0] {
    QuadI   = 2'd0,
    QuadII  = 2'd1,
    QuadIII = 2'd2,
    QuadIV  = 2'd3
  } ste_quad_e;

  // One frequency step issued by the sequencer
  typedef struct packed {
    logic             valid;
    logic [TsW-1:0]   ts;
    logic [FreqW-1:0] freq;
    logic [IdxW-1:0]  idx;
    logic             last;
  } ste_item_t;

  // Control that travels beside the sine pipeline
  typedef struct packed {
    logic            valid;
    ste_quad_e       quad;
    logic [IdxW-1:0] idx;
    logic            last;
  } ste_side_t;

endpackage

// File: sv/sinusoidal_timestep_embedding.sv
// The first result follows the phase, sine and output registers, then one per cycle.
// Throughput: a start is taken only while busy is low; busy stays high while the sequencer
// issues its frequencies, which sets the rate (one 32x32 frequency step per cycle).
// The 6-stage phase and sine pipeline never stalls; the receiver takes every strobe.
// Reset clears control and valid bits and loads half_count = 64 and the default ratio.
module sinusoidal_timestep_embedding (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ste_pkg::TsW-1:0]       timestep_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ste_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ste_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          out_strobe_o,
  output logic signed [ste_pkg::ValW-1:0] cos_value_o,
  output logic signed [ste_pkg::ValW-1:0] sin_value_o,
  output logic [ste_pkg::IdxW-1:0]      freq_index_o,
  output logic                          last_o
);

  logic [ste_pkg::CountW-1:0] half_count_q;
  logic [ste_pkg::FreqW-1:0]  freq_ratio_q;

  ste_pkg::ste_item_t         item;
  ste_pkg::ste_side_t         side1_q, side1_d;
  ste_pkg::ste_side_t         side_q [ste_pkg::SineLat];
  logic [ste_pkg::PhaseW-1:0] phase_q;
  logic [55:0]                pprod;
  logic [15:0]                z_s, z_c;
  logic [14:0]                s_mag, c_mag;
  logic signed [15:0]         s_pos, c_pos, s_neg, c_neg;
  logic signed [15:0]         cos_d, sin_d;
  logic                       strobe_q;
  logic signed [15:0]         cos_q, sin_q;
  logic [ste_pkg::IdxW-1:0]   idx_q;
  logic                       last_q;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_count_q <= ste_pkg::HalfCountRst;
      freq_ratio_q <= ste_pkg::FreqRatioRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ste_pkg::ste_cfg_idx_e'(cfg_index_i))
        ste_pkg::CfgHalfCount: half_count_q <= cfg_data_i[ste_pkg::CountW-1:0];
        ste_pkg::CfgFreqRatio: freq_ratio_q <= cfg_data_i[ste_pkg::FreqW-1:0];
        default: ;
      endcase
    end
  end

  ste_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .timestep_i  (timestep_i),
    .half_count_i(half_count_q),
    .freq_ratio_i(freq_ratio_q),
    .item_o      (item)
  );

  // Phase stage: timestep times frequency, fraction of a turn
  assign pprod = item.ts * item.freq;

  always_ff @(posedge clk_i) begin
    phase_q <= pprod[45:14];
  end

  // Split the phase into quadrant and angle within it
  assign z_s = {1'b0, phase_q[29:15]};
  assign z_c = ste_pkg::QuarterZ - z_s;

  always_comb begin
    side1_d.valid = item.valid;
    side1_d.quad  = ste_pkg::QuadI;
    side1_d.idx   = item.idx;
    side1_d.last  = item.last;
  end

  ste_qsine u_sin (
    .clk_i (clk_i),
    .z_i   (z_s),
    .sine_o(s_mag)
  );

  ste_qsine u_cos (
    .clk_i (clk_i),
    .z_i   (z_c),
    .sine_o(c_mag)
  );

  // Carry the control beside the sine pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      for (int i = 0; i < ste_pkg::SineLat; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side1_q   <= side1_d;
      side_q[0] <= '{valid: side1_q.valid,
                     quad:  ste_pkg::ste_quad_e'(phase_q[31:30]),
                     idx:   side1_q.idx,
                     last:  side1_q.last};
      for (int i = 1; i < ste_pkg::SineLat; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Fold the quarter wave into the right quadrant
  assign s_pos = {1'b0, s_mag};
  assign c_pos = {1'b0, c_mag};
  assign s_neg = 16'sd0 - s_pos;
  assign c_neg = 16'sd0 - c_pos;

  always_comb begin
    unique case (side_q[ste_pkg::SineLat-1].quad)
      ste_pkg::QuadI: begin
        cos_d = c_pos;
        sin_d = s_pos;
      end
      ste_pkg::QuadII: begin
        cos_d = s_neg;
        sin_d = c_pos;
      end
      ste_pkg::QuadIII: begin
        cos_d = c_neg;
        sin_d = s_neg;
      end
      default: begin
        cos_d = s_pos;
        sin_d = c_neg;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= side_q[ste_pkg::SineLat-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q  <= cos_d;
    sin_q  <= sin_d;
    idx_q  <= side_q[ste_pkg::SineLat-1].idx;
    last_q <= side_q[ste_pkg::SineLat-1].last;
  end

  assign out_strobe_o = strobe_q;
  assign cos_value_o  = cos_q;
  assign sin_value_o  = sin_q;
  assign freq_index_o = idx_q;
  assign last_o       = last_q & strobe_q;

endmodule

// File: sv/ste_seq.sv
// Sequencer: holds the timestep and steps the frequency once per result.
module ste_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ste_pkg::TsW-1:0]   timestep_i,
  input  logic [ste_pkg::CountW-1:0] half_count_i,
  input  logic [ste_pkg::FreqW-1:0] freq_ratio_i,
  output ste_pkg::ste_item_t        item_o
);

  logic                        busy_q, busy_d;
  logic [ste_pkg::TsW-1:0]     ts_q, ts_d;
  logic [ste_pkg::FreqW-1:0]   freq_q, freq_d;
  logic [ste_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [ste_pkg::IdxW-1:0]    last_idx_q, last_idx_d;
  logic [ste_pkg::IdxW-1:0]    last_idx_new;
  logic [63:0]                 fprod;
  logic [63:0]                 fround;
  logic                        is_last;

  // Clamp the count to 1..MaxHalf and keep its last index
  always_comb begin
    if (half_count_i == '0) begin
      last_idx_new = '0;
    end else if (half_count_i > ste_pkg::CountW'(ste_pkg::MaxHalf)) begin
      last_idx_new = ste_pkg::IdxW'(ste_pkg::MaxHalf - 1);
    end else begin
      last_idx_new = ste_pkg::IdxW'(half_count_i - 7'd1);
    end
  end

  // Rounded product of frequency and ratio
  assign fprod   = freq_q * freq_ratio_i;
  assign fround  = fprod + ste_pkg::FreqRound;
  assign is_last = (idx_q == last_idx_q);

  // Load on a start transfer, advance while busy
  always_comb begin
    busy_d     = busy_q;
    ts_d       = ts_q;
    freq_d     = freq_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    if (busy_q) begin
      freq_d = fround[63:32];
      idx_d  = idx_q + 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end
    end else if (start) begin
      busy_d     = 1'b1;
      ts_d       = timestep_i;
      freq_d     = ste_pkg::StartFreq;
      idx_d      = '0;
      last_idx_d = last_idx_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      ts_q       <= '0;
      freq_q     <= '0;
      idx_q      <= '0;
      last_idx_q <= '0;
    end else begin
      busy_q     <= busy_d;
      ts_q       <= ts_d;
      freq_q     <= freq_d;
      idx_q      <= idx_d;
      last_idx_q <= last_idx_d;
    end
  end

  assign busy         = busy_q;
  assign item_o.valid = busy_q;
  assign item_o.ts    = ts_q;
  assign item_o.freq  = freq_q;
  assign item_o.idx   = idx_q;
  assign item_o.last  = is_last;

endmodule

// File: sv/ste_qsine.sv
// Four-stage quarter-wave sine: Q1.15 angle in, Q1.14 magnitude out.
module ste_qsine (
  input  logic        clk_i,
  input  logic [15:0] z_i,
  output logic [14:0] sine_o
);

  logic [31:0] zsq;
  logic [28:0] cprod;
  logic [31:0] bprod;
  logic [32:0] aprod;
  logic [17:0] rnd;
  logic [15:0] scaled;

  logic [15:0] zz_q, zz_d;
  logic [15:0] z1_q;
  logic [15:0] t1_q, t1_d;
  logic [15:0] zz2_q;
  logic [15:0] z2_q;
  logic [16:0] t2_q, t2_d;
  logic [15:0] z3_q;
  logic [14:0] res_q, res_d;

  // Square of the angle
  assign zsq  = z_i * z_i;
  assign zz_d = zsq[30:15];

  // Innermost term
  assign cprod = ste_pkg::SinC * zz_q;
  assign t1_d  = ste_pkg::SinB - {2'b00, cprod[28:15]};

  // Middle term
  assign bprod = t1_q * zz2_q;
  assign t2_d  = ste_pkg::SinA - bprod[31:15];

  // Outer term, round to Q14 and cap at one
  assign aprod  = t2_q * z3_q;
  assign rnd    = aprod[32:15] + 18'd2;
  assign scaled = rnd[17:2];
  assign res_d  = (scaled > ste_pkg::SinOne) ? ste_pkg::SinOne[14:0] : scaled[14:0];

  always_ff @(posedge clk_i) begin
    zz_q  <= zz_d;
    z1_q  <= z_i;
    t1_q  <= t1_d;
    zz2_q <= zz_q;
    z2_q  <= z1_q;
    t2_q  <= t2_d;
    z3_q  <= z2_q;
    res_q <= res_d;
  end

  // z1_q feeds z2_q; the outer term reads z3_q
  assign sine_o = res_q;

endmodule
